FILE: hw/rtl/acrms_pkg.sv
// Package for the AC RMS meter with tracking offset removal.
// Holds field widths, fixed-point constants and the sequencer state type.
// No dependencies; every other file of the block imports it.
package acrms_pkg;

	// Field widths of the channel beats and the register
	localparam int SAMPLE_W = 12;
	localparam int RMS_W    = 16;
	localparam int OFF_W    = 16;
	localparam int USED_W   = 8;
	localparam int GAIN_W   = 32;

	// Defaults of the top-level parameters
	localparam int ADC_BITS_DEF    = 12;
	localparam int MAX_SAMPLES_DEF = 255;

	// Fixed-point formats
	localparam int FRAC_W     = 16;          // fraction bits of the zero point
	localparam int MAG_SHIFT  = 12;          // Q.16 -> Q.4
	localparam int SUM_W      = 48;          // square sum width
	localparam int ROOT_W     = SUM_W / 2;   // integer square root width
	localparam int GAIN_SHIFT = 20;          // Q.4 root times Q16 gain
	localparam int ALPHA_W    = 9;

	localparam logic [GAIN_W-1:0]  GAIN_RESET = 32'h0001_0000;
	localparam logic [ALPHA_W-1:0] ALPHA_Q16  = 9'd328;    // about 0.005
	localparam logic [FRAC_W-1:0]  ROUND_DN   = 16'hFFFF;  // ceil on the way down
	localparam logic [RMS_W-1:0]   RMS_MAX    = 16'hFFFF;
	localparam logic [OFF_W-1:0]   OFF_MAX    = 16'hFFFF;
	localparam logic [USED_W-1:0]  USED_MAX   = 8'hFF;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,   // wait for a beat
		ST_FILT,   // move the zero point toward the sample
		ST_MAG,    // centre the sample, load the squarer
		ST_SQR,    // shift-add square, one bit per cycle
		ST_ACC,    // add the square to the sum
		ST_PEND,   // period end: check for an empty period
		ST_DIV,    // restoring divide by the count, one bit per cycle
		ST_SQRT,   // square root, one root bit per cycle
		ST_GAIN,   // shift-add gain multiply, one bit per cycle
		ST_VOLT,   // scale and saturate the voltage
		ST_EMIT    // hand the result to the output register
	} state_t;

endpackage

FILE: hw/rtl/acrms_in_if.sv
// Input channel of the AC RMS meter: valid/ready plus one sample beat.
// Depends on acrms_pkg for the field widths.
interface acrms_in_if
	import acrms_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample;
	logic                sample_valid;
	logic                period_end;

	modport source (output valid, output sample, output sample_valid, output period_end,
		input ready);
	modport sink (input valid, input sample, input sample_valid, input period_end,
		output ready);
endinterface

FILE: hw/rtl/acrms_out_if.sv
// Output channel of the AC RMS meter: valid/ready plus one result beat.
// Depends on acrms_pkg for the field widths.
interface acrms_out_if
	import acrms_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [RMS_W-1:0]  rms_centivolts;
	logic [OFF_W-1:0]  offset_q4;
	logic              fresh;
	logic [USED_W-1:0] samples_used;

	modport source (output valid, output rms_centivolts, output offset_q4, output fresh,
		output samples_used, input ready);
	modport sink (input valid, input rms_centivolts, input offset_q4, input fresh,
		input samples_used, output ready);
endinterface

FILE: hw/rtl/ac_rms_meter_tracking_offset_top.sv
// True-RMS meter with IIR DC removal. Each beat may carry an ADC sample and a
// period-end mark. A sample runs the filter, centring, a bit-serial square of
// ADC_BITS+4 steps and the accumulate (once MAX_SAMPLES are summed, it is not squared);
// a period end with samples adds a 48-step restoring divide, a 24-step square root,
// a 24-step gain multiply, scaling and hand-off; an empty one goes straight to hand-off.
// All of it runs on one sequencer and one shift-add unit, so a new beat is taken only
// when the previous one is done; the result sits in an output register, so a waiting
// result stalls the next period end only, not the samples in between.
// Depends on acrms_pkg, acrms_in_if and acrms_out_if.
module ac_rms_meter_tracking_offset_top
	import acrms_pkg::*;
#(
	parameter int ADC_BITS    = ADC_BITS_DEF,
	parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [GAIN_W-1:0] cfg_wdata,
	acrms_in_if.sink          in_ch,
	acrms_out_if.source       out_ch
);

	localparam int ZW     = ADC_BITS + FRAC_W;          // zero point width
	localparam int MAG_W  = ZW - MAG_SHIFT;             // centred magnitude, Q.4
	localparam int CW     = $clog2(MAX_SAMPLES + 1);    // sample counter width
	localparam int EXT_W  = ADC_BITS + SAMPLE_W;
	localparam int PRD_W  = ZW + ALPHA_W + 1;           // filter product plus rounding
	localparam int MUL_W  = ROOT_W + GAIN_W;            // shift-add accumulator
	localparam int VOLT_W = MUL_W - GAIN_SHIFT;
	localparam int STEP_W = $clog2(SUM_W);
	localparam logic [STEP_W-1:0] SQR_LAST  = STEP_W'(MAG_W - 1);
	localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(SUM_W - 1);
	localparam logic [STEP_W-1:0] ROOT_LAST = STEP_W'(ROOT_W - 1);
	localparam logic [CW-1:0]     CNT_MAX   = CW'(MAX_SAMPLES);
	localparam logic [ZW-1:0]     ZP_RESET  = ZW'(1) << (ZW - 1);

	state_t state_q, state_d;

	logic [GAIN_W-1:0]   gain_q;
	logic [ADC_BITS-1:0] raw_q;
	logic                pend_q;
	logic [ZW-1:0]       zp_q;
	logic [SUM_W-1:0]    sum_q;      // square sum, then dividend/quotient, then radicand
	logic [CW-1:0]       cnt_q;
	logic [RMS_W-1:0]    held_q;
	logic [CW-1:0]       rem_q;      // divider remainder
	logic [ROOT_W:0]     srem_q;     // square root remainder
	logic [MUL_W-1:0]    mcand_q;
	logic [ROOT_W-1:0]   mplier_q;   // multiplier bits, also the root as it forms
	logic [MUL_W-1:0]    acc_q;
	logic [STEP_W-1:0]   step_q;

	logic              out_valid_q;
	logic [RMS_W-1:0]  out_rms_q;
	logic [OFF_W-1:0]  out_off_q;
	logic              out_fresh_q;
	logic [USED_W-1:0] out_used_q;

	logic in_ready;
	logic emit_go;
	logic in_take;

	// Mask the sample to the converter width
	logic [EXT_W-1:0]    samp_ext;
	logic [ADC_BITS-1:0] raw_in;
	assign samp_ext = EXT_W'(in_ch.sample);
	assign raw_in   = samp_ext[ADC_BITS-1:0];

	// Low-pass step: zp += floor((target - zp) * alpha / 2^16)
	logic [ZW-1:0]    target;
	logic             tgt_ge;
	logic [ZW-1:0]    zp_gap;
	logic [PRD_W-1:0] prod;
	logic [PRD_W-1:0] prod_rnd;
	logic [ZW-1:0]    zp_step;
	logic [ZW-1:0]    zp_next;
	always_comb begin
		target   = {raw_q, FRAC_W'(0)};
		tgt_ge   = target >= zp_q;
		zp_gap   = tgt_ge ? target - zp_q : zp_q - target;
		prod     = PRD_W'(zp_gap) * PRD_W'(ALPHA_Q16);
		prod_rnd = prod + (tgt_ge ? PRD_W'(0) : PRD_W'(ROUND_DN));
		zp_step  = ZW'(prod_rnd >> FRAC_W);
		zp_next  = tgt_ge ? zp_q + zp_step : zp_q - zp_step;
	end

	// Centred magnitude against the updated zero point
	logic [ZW-1:0]    cdist;
	logic [MAG_W-1:0] mag;
	assign cdist = (target >= zp_q) ? target - zp_q : zp_q - target;
	assign mag   = cdist[ZW-1:MAG_SHIFT];

	// Saturating accumulate of the square
	logic [SUM_W:0] sum_add;
	assign sum_add = {1'b0, sum_q} + (SUM_W+1)'(acc_q[2*MAG_W-1:0]);

	// Restoring divide step
	logic [CW:0] rem_sh;
	logic        div_ge;
	logic [CW:0] rem_sub;
	assign rem_sh  = {rem_q, sum_q[SUM_W-1]};
	assign div_ge  = rem_sh >= {1'b0, cnt_q};
	assign rem_sub = rem_sh - {1'b0, cnt_q};

	// Square root step: two radicand bits in, one root bit out
	logic [ROOT_W+2:0] srem_sh;
	logic [ROOT_W+2:0] trial;
	logic              sqrt_ge;
	logic [ROOT_W+2:0] srem_sub;
	assign srem_sh  = {srem_q, sum_q[SUM_W-1:SUM_W-2]};
	assign trial    = {1'b0, mplier_q, 2'b01};
	assign sqrt_ge  = srem_sh >= trial;
	assign srem_sub = srem_sh - trial;

	// Scale and saturate the voltage; saturate offset and count
	logic [VOLT_W-1:0] volts;
	logic [RMS_W-1:0]  volts_sat;
	logic [MAG_W-1:0]  off_full;
	logic [OFF_W-1:0]  off_sat;
	logic [USED_W-1:0] used_sat;
	always_comb begin
		volts     = acc_q[MUL_W-1:GAIN_SHIFT];
		volts_sat = (volts > VOLT_W'(RMS_MAX)) ? RMS_MAX : volts[RMS_W-1:0];
		off_full  = zp_q[ZW-1:MAG_SHIFT];
		off_sat   = (off_full > MAG_W'(OFF_MAX)) ? OFF_MAX : OFF_W'(off_full);
		used_sat  = (cnt_q > CW'(USED_MAX)) ? USED_MAX : USED_W'(cnt_q);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_take) begin
					if (in_ch.sample_valid) state_d = ST_FILT;
					else if (in_ch.period_end) state_d = ST_PEND;
				end
			end
			ST_FILT: state_d = ST_MAG;
			ST_MAG: begin
				if (cnt_q < CNT_MAX) state_d = ST_SQR;
				else if (pend_q) state_d = ST_PEND;
				else state_d = ST_IDLE;
			end
			ST_SQR:  if (step_q == SQR_LAST) state_d = ST_ACC;
			ST_ACC:  state_d = pend_q ? ST_PEND : ST_IDLE;
			ST_PEND: state_d = (cnt_q == '0) ? ST_EMIT : ST_DIV;
			ST_DIV:  if (step_q == DIV_LAST) state_d = ST_SQRT;
			ST_SQRT: if (step_q == ROOT_LAST) state_d = ST_GAIN;
			ST_GAIN: if (step_q == ROOT_LAST) state_d = ST_VOLT;
			ST_VOLT: state_d = ST_EMIT;
			ST_EMIT: if (emit_go) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Handshake outputs of the sequencer
	always_comb begin
		in_ready = 1'b0;
		emit_go  = 1'b0;
		unique case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_EMIT: emit_go  = !out_valid_q || out_ch.ready;
			default: begin
				in_ready = 1'b0;
				emit_go  = 1'b0;
			end
		endcase
	end

	assign in_take     = in_ch.valid && in_ready;
	assign in_ch.ready = in_ready;

	// Control state and the register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			gain_q      <= GAIN_RESET;
			zp_q        <= ZP_RESET;
			sum_q       <= '0;
			cnt_q       <= '0;
			held_q      <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) gain_q <= cfg_wdata;
			// Raise valid on a hand-off, drop it once the beat is taken
			if (emit_go) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_FILT: zp_q <= zp_next;
				ST_MAG:  step_q <= '0;
				ST_SQR:  step_q <= step_q + 1'b1;
				ST_ACC: begin
					sum_q <= sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
					cnt_q <= cnt_q + 1'b1;
				end
				ST_PEND: step_q <= '0;
				ST_DIV: begin
					// quotient bits shift in behind the dividend
					sum_q  <= {sum_q[SUM_W-2:0], div_ge};
					step_q <= (step_q == DIV_LAST) ? '0 : step_q + 1'b1;
				end
				ST_SQRT: begin
					sum_q  <= {sum_q[SUM_W-3:0], 2'b00};
					step_q <= (step_q == ROOT_LAST) ? '0 : step_q + 1'b1;
				end
				ST_GAIN: step_q <= step_q + 1'b1;
				ST_VOLT: held_q <= volts_sat;
				ST_EMIT: begin
					if (emit_go) begin
						sum_q <= '0;
						cnt_q <= '0;
					end
				end
				default: begin
					step_q <= step_q;
				end
			endcase
		end
	end

	// Datapath shift registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_take) begin
					raw_q  <= raw_in;
					pend_q <= in_ch.period_end;
				end
			end
			ST_MAG: begin
				mcand_q  <= MUL_W'(mag);
				mplier_q <= ROOT_W'(mag);
				acc_q    <= '0;
			end
			ST_SQR, ST_GAIN: begin
				if (mplier_q[0]) acc_q <= acc_q + mcand_q;
				mcand_q  <= {mcand_q[MUL_W-2:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[ROOT_W-1:1]};
			end
			ST_PEND: rem_q <= '0;
			ST_DIV: begin
				rem_q    <= div_ge ? rem_sub[CW-1:0] : rem_sh[CW-1:0];
				srem_q   <= '0;
				mplier_q <= '0;
			end
			ST_SQRT: begin
				srem_q   <= sqrt_ge ? srem_sub[ROOT_W:0] : srem_sh[ROOT_W:0];
				mplier_q <= {mplier_q[ROOT_W-2:0], sqrt_ge};
				mcand_q  <= MUL_W'(gain_q);
				acc_q    <= '0;
			end
			ST_EMIT: begin
				if (emit_go) begin
					out_rms_q   <= held_q;
					out_off_q   <= off_sat;
					out_fresh_q <= cnt_q != '0;
					out_used_q  <= used_sat;
				end
			end
			default: begin
				rem_q <= rem_q;
			end
		endcase
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.rms_centivolts = out_rms_q;
	assign out_ch.offset_q4      = out_off_q;
	assign out_ch.fresh          = out_fresh_q;
	assign out_ch.samples_used   = out_used_q;

	// Counter never passes its limit
	a_cnt_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_MAX)
		else $error("sample counter above limit");

	// Divider remainder stays below the divisor
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> rem_q < cnt_q)
		else $error("divider remainder not below count");

	// A hand-off clears the period and shows a result
	a_emit_clear: assert property (@(posedge clk) disable iff (!arst_n)
		emit_go |=> (out_valid_q && cnt_q == '0 && sum_q == '0))
		else $error("period not cleared after hand-off");

	// Fresh exactly when the period held samples
	a_fresh_used: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_fresh_q == (out_used_q != '0)))
		else $error("fresh flag disagrees with sample count");

	// No beat is taken while the sequencer works
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ch.ready)
		else $error("input ready while busy");

endmodule
